@@ src/int8_dot_product_requantize_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the int8 dot product requantizer
// Shared helpers that wrap a clocked implication with reset disable.
// ----------------------------------------------------------------------------
`ifndef INT8_DOT_PRODUCT_REQUANTIZE_ASSERT_SVH
`define INT8_DOT_PRODUCT_REQUANTIZE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IDPR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define IDPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/idpr_pkg.sv @@
// ----------------------------------------------------------------------------
// idpr_pkg
// Types and constants shared by the dot product front end, queue and back end.
// ----------------------------------------------------------------------------
package idpr_pkg;

	// Operand bytes per beat that the lanes consume, and bytes carried by the ports.
	localparam int SRC_BYTES   = 16;
	localparam int PORT_BYTES  = 16;
	localparam int NUM_LANES   = SRC_BYTES / 4;
	localparam int SCALE_FRAC  = 24;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Width of the rounded, signed requantized value before clamping.
	localparam int RND_W = 64 - SCALE_FRAC + 1;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_CLAMP_LOW  = 1'b0,
		REG_CLAMP_HIGH = 1'b1
	} cfg_reg_t;

	typedef logic signed [31:0] lane_word_t;
	typedef lane_word_t [NUM_LANES-1:0] lane_arr_t;

	// One finished dot product waiting for reduction and requantization.
	typedef struct packed {
		lane_arr_t         lanes;
		logic signed [31:0] bias;
		logic signed [31:0] scale;
		logic               mode;
	} job_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SUM,
		BK_MUL,
		BK_RND,
		BK_OUT
	} back_state_t;

endpackage

@@ src/idpr_front.sv @@
// ----------------------------------------------------------------------------
// idpr_front
// Accepts operand beats and keeps the saturating lane accumulators.
// ----------------------------------------------------------------------------
module idpr_front
	import idpr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [63:0]        src_bytes_lo,
	input  logic [63:0]        src_bytes_hi,
	input  logic [63:0]        wgt_bytes_lo,
	input  logic [63:0]        wgt_bytes_hi,
	input  logic signed [31:0] chan_bias,
	input  logic signed [31:0] chan_scale,
	input  logic               mode,
	input  logic               last,
	input  queue_stat_t        q_stat,
	output logic               push,
	output job_t               push_job
);

	lane_arr_t                   acc_q;
	lane_arr_t                   lanes_next;
	logic [8*PORT_BYTES-1:0]     src_all;
	logic [8*PORT_BYTES-1:0]     wgt_all;
	logic                        accept;

	assign src_all = {src_bytes_hi, src_bytes_lo};
	assign wgt_all = {wgt_bytes_hi, wgt_bytes_lo};

	// A beat is taken whenever the queue can hold a possible result.
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && last;

	// Each lane adds four byte products and saturates to signed 32 bits.
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		logic signed [16:0] prod [4];
		logic signed [18:0] psum;
		logic signed [33:0] wide;
		lane_word_t         sat;

		for (genvar j = 0; j < 4; j++) begin : g_byte
			localparam int K = 4 * i + j;
			if (K < PORT_BYTES) begin : g_used
				assign prod[j] = $signed({1'b0, src_all[8*K +: 8]})
					* $signed(wgt_all[8*K +: 8]);
			end else begin : g_zero
				assign prod[j] = '0;
			end
		end

		assign psum = 19'(prod[0]) + 19'(prod[1]) + 19'(prod[2]) + 19'(prod[3]);
		assign wide = 34'(acc_q[i]) + 34'(psum);

		always_comb begin
			if (wide > 34'sh0_7FFF_FFFF) begin
				sat = 32'sh7FFF_FFFF;
			end else if (wide < -34'sh0_8000_0000) begin
				sat = 32'sh8000_0000;
			end else begin
				sat = wide[31:0];
			end
		end

		assign lanes_next[i] = sat;
	end

	// Accumulators clear after the closing beat of a dot product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= last ? '0 : lanes_next;
		end
	end

	always_comb begin
		push_job.lanes = lanes_next;
		push_job.bias  = chan_bias;
		push_job.scale = chan_scale;
		push_job.mode  = mode;
	end

endmodule

@@ src/idpr_queue.sv @@
// ----------------------------------------------------------------------------
// idpr_queue
// Short first-in first-out buffer of finished dot products.
// ----------------------------------------------------------------------------
module idpr_queue
	import idpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  job_t        push_job,
	input  logic        pop,
	output job_t        head_job,
	output queue_stat_t q_stat
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_job     = mem_q[rd_ptr_q];

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/idpr_back.sv @@
// ----------------------------------------------------------------------------
// idpr_back
// Reduces the lanes, adds bias, optionally requantizes and holds the result beat.
// ----------------------------------------------------------------------------
module idpr_back
	import idpr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  queue_stat_t        q_stat,
	input  job_t               head_job,
	output logic               pop,
	input  logic signed [7:0]  clamp_low,
	input  logic signed [7:0]  clamp_high,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic               result_quantized
);

	back_state_t               state_q;
	back_state_t               state_d;
	job_t                      job_q;
	logic signed [31:0]        sum_q;
	logic signed [63:0]        prod_q;
	logic signed [RND_W-1:0]   val_q;
	logic                      out_valid_q;
	logic signed [31:0]        result_value_q;
	logic                      result_quantized_q;
	logic                      load_job;
	logic                      do_sum;
	logic                      do_mul;
	logic                      do_rnd;
	logic                      do_out;
	logic                      out_free;
	logic signed [31:0]        lane_sum;
	logic [63:0]               mag;
	logic [63:0]               mag_rnd;
	logic [RND_W-2:0]          mag_shift;
	logic signed [RND_W-1:0]   clamp_hi_ext;
	logic signed [RND_W-1:0]   clamp_lo_ext;
	logic signed [RND_W-1:0]   v_hi;
	logic signed [RND_W-1:0]   v_lo;
	logic signed [7:0]         q8;

	assign out_free = !out_valid_q || out_ready;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!q_stat.empty) state_d = BK_SUM;
			BK_SUM:  state_d = BK_MUL;
			BK_MUL:  state_d = BK_RND;
			BK_RND:  state_d = BK_OUT;
			BK_OUT:  if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Step enables decoded from the state.
	always_comb begin
		load_job = 1'b0;
		do_sum   = 1'b0;
		do_mul   = 1'b0;
		do_rnd   = 1'b0;
		do_out   = 1'b0;
		case (state_q)
			BK_IDLE: load_job = !q_stat.empty;
			BK_SUM:  do_sum   = 1'b1;
			BK_MUL:  do_mul   = 1'b1;
			BK_RND:  do_rnd   = 1'b1;
			BK_OUT:  do_out   = out_free;
			default: load_job = 1'b0;
		endcase
	end

	assign pop = load_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lane reduction and bias, both wrapping at 32 bits.
	always_comb begin
		lane_sum = job_q.bias;
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_sum = lane_sum + job_q.lanes[i];
		end
	end

	// Round half away from zero on the magnitude of the product.
	always_comb begin
		mag       = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
		mag_rnd   = mag + (64'd1 << (SCALE_FRAC - 1));
		mag_shift = mag_rnd[63:SCALE_FRAC];
	end

	// Clamp to the register bounds, then saturate to int8.
	always_comb begin
		clamp_hi_ext = RND_W'(clamp_high);
		clamp_lo_ext = RND_W'(clamp_low);
		v_hi = (val_q > clamp_hi_ext) ? clamp_hi_ext : val_q;
		v_lo = (v_hi < clamp_lo_ext) ? clamp_lo_ext : v_hi;
		if (v_lo > RND_W'(127)) begin
			q8 = 8'sd127;
		end else if (v_lo < -RND_W'(128)) begin
			q8 = -8'sd128;
		end else begin
			q8 = v_lo[7:0];
		end
	end

	// Datapath registers of the back end.
	always_ff @(posedge clk) begin
		if (load_job) begin
			job_q <= head_job;
		end
		if (do_sum) begin
			sum_q <= lane_sum;
		end
		if (do_mul) begin
			prod_q <= sum_q * job_q.scale;
		end
		if (do_rnd) begin
			val_q <= prod_q[63] ? -$signed({1'b0, mag_shift}) : $signed({1'b0, mag_shift});
		end
		if (do_out) begin
			result_value_q     <= job_q.mode ? 32'(q8) : sum_q;
			result_quantized_q <= job_q.mode;
		end
	end

	// Output beat stays until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_value     = result_value_q;
	assign result_quantized = result_quantized_q;

endmodule

@@ src/int8_dot_product_requantize.sv @@
// ----------------------------------------------------------------------------
// int8_dot_product_requantize
// One output of a quantized matrix product with optional int8 requantization.
//
//   Channel   Handshake               Payload
//   in        in_valid / in_ready     src/wgt bytes, chan_bias, chan_scale,
//                                     mode, last
//   out       out_valid / out_ready   result_value, result_quantized
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The front end takes one input beat per cycle into the lane accumulators.
// A closing beat (last) hands its lanes to a two-entry queue; the back end
// works through each result in order (load, reduce, multiply, round, clamp)
// and takes the next entry only after the result beat is registered. Input
// stalls only when the queue is full. Reset clears the accumulators and sets
// the clamp bounds to the full int8 range. Configuration writes never stall.
// ----------------------------------------------------------------------------
module int8_dot_product_requantize
	import idpr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [63:0]        src_bytes_lo,
	input  logic [63:0]        src_bytes_hi,
	input  logic [63:0]        wgt_bytes_lo,
	input  logic [63:0]        wgt_bytes_hi,
	input  logic signed [31:0] chan_bias,
	input  logic signed [31:0] chan_scale,
	input  logic               mode,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic               result_quantized,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

`include "int8_dot_product_requantize_assert.svh"

	queue_stat_t       q_stat;
	logic              push;
	job_t              push_job;
	logic              pop;
	job_t              head_job;
	logic signed [7:0] clamp_low_q;
	logic signed [7:0] clamp_high_q;

	// Clamp registers, written whenever cfg_valid is high.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_low_q  <= -8'sd128;
			clamp_high_q <= 8'sd127;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CLAMP_LOW:  clamp_low_q  <= cfg_data;
				REG_CLAMP_HIGH: clamp_high_q <= cfg_data;
				default:        clamp_low_q  <= clamp_low_q;
			endcase
		end
	end

	idpr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.src_bytes_lo (src_bytes_lo),
		.src_bytes_hi (src_bytes_hi),
		.wgt_bytes_lo (wgt_bytes_lo),
		.wgt_bytes_hi (wgt_bytes_hi),
		.chan_bias    (chan_bias),
		.chan_scale   (chan_scale),
		.mode         (mode),
		.last         (last),
		.q_stat       (q_stat),
		.push         (push),
		.push_job     (push_job)
	);

	idpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	idpr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_stat           (q_stat),
		.head_job         (head_job),
		.pop              (pop),
		.clamp_low        (clamp_low_q),
		.clamp_high       (clamp_high_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_value     (result_value),
		.result_quantized (result_quantized)
	);

	// The queue never takes a closing beat while it is full.
	`IDPR_ASSERT_SAME(a_no_overflow, push, !q_stat.full, "queue overflow")

	// The back end never pops an empty queue.
	`IDPR_ASSERT_SAME(a_no_underflow, pop, !q_stat.empty, "queue underflow")

	// A requantized result is a sign-extended int8 no lower than the lower bound.
	`IDPR_ASSERT_SAME(a_quant_range, out_valid && result_quantized, (result_value[31:7] == '0 || result_value[31:7] == '1) && ($signed(result_value) >= 32'(clamp_low_q)), "requantized result out of range")

endmodule
